// ===== rtl/udpd_pkg.sv =====
`default_nettype none

package udpd_pkg;

  // Item opcodes; code 3 is unused and yields an all-zero result
  typedef enum logic [1:0] {
    OP_BIND    = 2'd0,
    OP_UNBIND  = 2'd1,
    OP_DELIVER = 2'd2
  } udpd_op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SHORT = 2'd2
  } udpd_status_e;

  localparam int unsigned PortW   = 16;
  localparam int unsigned LenW    = 16;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned MaskW   = 8;
  localparam logic [LenW-1:0] HdrBytes = 16'd8;

  // Table command issued when a transaction leaves the input register
  typedef struct packed {
    logic             bind_en;
    logic             unbind_en;
    logic [PortW-1:0] port;
  } udpd_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/udpd_slot_table.sv =====
`default_nettype none

module udpd_slot_table
  import udpd_pkg::*;
#(
  parameter int unsigned SLOTS = 8,
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire udpd_cmd_t        cmd_i,
  input  wire logic [PortW-1:0] lookup_port_i,
  output logic [SLOTS-1:0]      match_o,
  output logic                  free_found_o,
  output logic [IdxW-1:0]       free_idx_o
);

  logic [SLOTS-1:0] slot_valid_q, slot_valid_d;
  logic [PortW-1:0] slot_port_q [SLOTS];
  logic [SLOTS-1:0] unbind_hit;

  // Compare every valid slot against the looked-up port
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_o[i]    = slot_valid_q[i] && (slot_port_q[i] == lookup_port_i);
      unbind_hit[i] = slot_valid_q[i] && (slot_port_q[i] == cmd_i.port);
    end
  end

  // Find the lowest free slot
  always_comb begin
    free_found_o = 1'b0;
    free_idx_o   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid_q[i]) begin
        free_found_o = 1'b1;
        free_idx_o   = IdxW'(i);
      end
    end
  end

  // Set the claimed slot on bind, drop every matching slot on unbind
  always_comb begin
    slot_valid_d = slot_valid_q;
    if (cmd_i.bind_en && free_found_o) begin
      slot_valid_d[free_idx_o] = 1'b1;
    end
    if (cmd_i.unbind_en) begin
      slot_valid_d = slot_valid_q & ~unbind_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else begin
      slot_valid_q <= slot_valid_d;
    end
  end

  // Store the port of a new binding
  always_ff @(posedge clk_i) begin
    if (cmd_i.bind_en && free_found_o) begin
      slot_port_q[free_idx_o] <= cmd_i.port;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/udp_port_demux_table.sv =====
`default_nettype none

// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    op_i, port_i, peer_port_i, datagram_length_i
// out      out_valid_o / out_ready_i  status_o, slot_o, match_mask_o,
//                                     payload_length_o, source_port_out_o
//
// One transaction per cycle while out is not stalled: it is registered on
// entry, then the slot comparators and the free-slot encoder settle it
// combinationally into the result register.
// Reset clears all slot valid bits and both handshake stages.
// A stall on out backs up into the input register; in_ready_o stays high
// while the input register is empty or drains in the same cycle.

module udp_port_demux_table
  import udpd_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [PortW-1:0] port_i,
  input  wire logic [PortW-1:0] peer_port_i,
  input  wire logic [LenW-1:0]  datagram_length_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            status_o,
  output logic [SlotW-1:0]      slot_o,
  output logic [MaskW-1:0]      match_mask_o,
  output logic [LenW-1:0]       payload_length_o,
  output logic [PortW-1:0]      source_port_out_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic             in_valid_q;
  logic [1:0]       op_q;
  logic [PortW-1:0] port_q, src_q;
  logic [LenW-1:0]  len_q;

  logic             out_valid_q;
  logic [1:0]       status_q, status_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [MaskW-1:0] mask_q, mask_d;
  logic [LenW-1:0]  plen_q, plen_d;
  logic [PortW-1:0] sport_q, sport_d;

  logic             advance, fire, in_take;
  udpd_cmd_t        cmd;
  logic [SLOTS-1:0] match;
  logic             free_found;
  logic [IdxW-1:0]  free_idx;
  logic [31:0]      idx_ext;
  logic [SLOTS+MaskW-1:0] mask_ext;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // Hold the input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= op_i;
      port_q <= port_i;
      src_q  <= peer_port_i;
      len_q  <= datagram_length_i;
    end
  end

  // Table update only when the transaction moves on
  always_comb begin
    cmd.bind_en   = fire && (op_q == OP_BIND);
    cmd.unbind_en = fire && (op_q == OP_UNBIND);
    cmd.port      = port_q;
  end

  udpd_slot_table #(
    .SLOTS(SLOTS)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .lookup_port_i(port_q),
    .match_o      (match),
    .free_found_o (free_found),
    .free_idx_o   (free_idx)
  );

  assign idx_ext  = 32'(free_idx);
  assign mask_ext = (SLOTS + MaskW)'(match);

  // Build the result
  always_comb begin
    status_d = ST_OK;
    slot_d   = '0;
    mask_d   = '0;
    plen_d   = '0;
    sport_d  = '0;
    case (op_q)
      OP_BIND: begin
        if (free_found) begin
          slot_d = idx_ext[SlotW-1:0];
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_UNBIND: begin
        status_d = ST_OK;
      end
      OP_DELIVER: begin
        if (len_q < HdrBytes) begin
          status_d = ST_SHORT;
        end else begin
          mask_d  = mask_ext[MaskW-1:0];
          plen_d  = len_q - HdrBytes;
          sport_d = src_q;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      mask_q   <= mask_d;
      plen_q   <= plen_d;
      sport_q  <= sport_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign slot_o            = slot_q;
  assign match_mask_o      = mask_q;
  assign payload_length_o  = plen_q;
  assign source_port_out_o = sport_q;

endmodule

`default_nettype wire
